>>> rtl/ccfr_pkg.sv
// ----------------------------------------------------------------------------
// ccfr_pkg: shared constants, types and functions of the card frame responder
// Field widths, opcode and status codes, the command/status structs between
// controller and datapath, and the reflected CRC-16 byte step.
// ----------------------------------------------------------------------------
package ccfr_pkg;

	// card memory depth and field widths
	localparam int unsigned MAX_BLOCKS = 32;
	localparam int unsigned IDX_W      = 5;
	localparam int unsigned OPCODE_W   = 8;
	localparam int unsigned LEN_W      = 4;
	localparam int unsigned PAYLOAD_W  = 64;
	localparam int unsigned STATUS_W   = 3;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 6;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_SOF    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_BYTE   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_REJECT = 3'd2;
	localparam logic [STATUS_W-1:0] ST_IGNORE = 3'd3;
	localparam logic [STATUS_W-1:0] ST_ERROR  = 3'd4;

	// request opcodes
	localparam logic [OPCODE_W-1:0] OP_ACTIVATE  = 8'h0A;
	localparam logic [OPCODE_W-1:0] OP_IDENTIFY  = 8'h0C;
	localparam logic [OPCODE_W-1:0] OP_SELECT    = 8'h81;
	localparam logic [OPCODE_W-1:0] OP_HALT      = 8'h00;
	localparam logic [OPCODE_W-1:0] OP_READ_ONE  = 8'h0C;
	localparam logic [OPCODE_W-1:0] OP_READ_FOUR = 8'h06;

	// request frame lengths
	localparam logic [LEN_W-1:0] LEN_SHORT  = 4'd1;
	localparam logic [LEN_W-1:0] LEN_READ   = 4'd4;
	localparam logic [LEN_W-1:0] LEN_SELECT = 4'd9;

	// CRC-16, reflected
	localparam logic [15:0] CRC_INIT = 16'hE012;
	localparam logic [15:0] CRC_POLY = 16'h8408;

	// configuration register indexes and reset values
	localparam logic [CFG_IDX_W-1:0]  REG_BLK_LIMIT     = 2'd0;
	localparam logic [CFG_IDX_W-1:0]  REG_RESPONSE_ROOM = 2'd1;
	localparam logic [CFG_DATA_W-1:0] BLK_LIMIT_RST     = 6'd32;
	localparam logic [CFG_DATA_W-1:0] ROOM_RST          = 6'd34;

	// response sizes in bytes, CRC included
	localparam logic [CFG_DATA_W-1:0] RSP_LEN_WORD = 6'd10;
	localparam logic [CFG_DATA_W-1:0] RSP_LEN_FOUR = 6'd34;

	// blocks that always read as all ones
	localparam logic [IDX_W-1:0] MASK_BLK_A = 5'd3;
	localparam logic [IDX_W-1:0] MASK_BLK_B = 5'd4;

	typedef enum logic [1:0] {
		WSRC_ROT,
		WSRC_RAW,
		WSRC_BLK
	} word_src_t;

	typedef enum logic [1:0] {
		OSEL_SINGLE,
		OSEL_DATA,
		OSEL_CRC_LO,
		OSEL_CRC_HI
	} out_sel_t;

	// controller -> datapath
	typedef struct packed {
		logic                mem_we;
		logic                req_we;
		logic                rd_en;
		logic                rd_blk0;
		logic                word_we;
		word_src_t           word_src;
		logic                blk_init;
		logic                blk_adv;
		logic                crc_init;
		logic                out_we;
		out_sel_t            out_sel;
		logic [STATUS_W-1:0] out_status;
	} ccfr_ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic len_zero;
		logic is_act;
		logic is_ident;
		logic is_sel;
		logic is_halt;
		logic is_read;
		logic rd_four;
		logic match_rot;
		logic match_raw;
		logic crc_ok;
		logic range_ok;
		logic fit_word;
		logic fit_read;
	} ccfr_stat_t;

	// one byte through the reflected CRC-16
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

>>> rtl/ccfr_if.sv
// ----------------------------------------------------------------------------
// ccfr_if: channel interfaces of the card frame responder
// Request channel, response channel and configuration write channel, each
// with valid/ready and its payload.
// ----------------------------------------------------------------------------
interface ccfr_req_if;
	logic                               valid;
	logic                               ready;
	logic                               cmd;
	logic [ccfr_pkg::OPCODE_W-1:0]      opcode;
	logic [ccfr_pkg::LEN_W-1:0]         frame_length;
	logic [ccfr_pkg::PAYLOAD_W-1:0]     payload;
	logic [ccfr_pkg::IDX_W-1:0]         load_index;

	modport source (output valid, cmd, opcode, frame_length, payload, load_index,
		input ready);
	modport sink (input valid, cmd, opcode, frame_length, payload, load_index,
		output ready);
endinterface

interface ccfr_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [ccfr_pkg::STATUS_W-1:0] status;
	logic [7:0]                    data_byte;
	logic                          last;

	modport source (output valid, status, data_byte, last, input ready);
	modport sink (input valid, status, data_byte, last, output ready);
endinterface

interface ccfr_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [ccfr_pkg::CFG_IDX_W-1:0]  index;
	logic [ccfr_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/ccfr_dp.sv
// ----------------------------------------------------------------------------
// ccfr_dp: datapath of the card frame responder
// Card memory, request and config registers, frame decode flags, response
// word shifter, CRC accumulator and the response output register.
// ----------------------------------------------------------------------------
module ccfr_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ccfr_pkg::ccfr_ctl_t                 ctl,
	output ccfr_pkg::ccfr_stat_t                stat,
	input  logic [ccfr_pkg::OPCODE_W-1:0]       opcode,
	input  logic [ccfr_pkg::LEN_W-1:0]          frame_length,
	input  logic [ccfr_pkg::PAYLOAD_W-1:0]      payload,
	input  logic [ccfr_pkg::IDX_W-1:0]          load_index,
	input  logic                                cfg_valid,
	input  logic [ccfr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ccfr_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic [ccfr_pkg::STATUS_W-1:0]       status,
	output logic [7:0]                          data_byte,
	output logic                                last
);

	logic [ccfr_pkg::PAYLOAD_W-1:0]  mem [ccfr_pkg::MAX_BLOCKS];
	logic [ccfr_pkg::PAYLOAD_W-1:0]  rdata_q;
	logic [ccfr_pkg::IDX_W-1:0]      rd_addr;
	logic [ccfr_pkg::OPCODE_W-1:0]   op_q;
	logic [ccfr_pkg::LEN_W-1:0]      len_q;
	logic [ccfr_pkg::PAYLOAD_W-1:0]  pay_q;
	logic [ccfr_pkg::PAYLOAD_W-1:0]  word_q;
	logic [ccfr_pkg::IDX_W-1:0]      blk_q;
	logic [15:0]                     crc_q;
	logic [ccfr_pkg::CFG_DATA_W-1:0] blk_limit_q;
	logic [ccfr_pkg::CFG_DATA_W-1:0] room_q;
	logic [ccfr_pkg::CFG_DATA_W-1:0] limit;
	logic [8:0]                      rd_end;
	logic [ccfr_pkg::PAYLOAD_W-1:0]  rot_serial;
	logic                            blk_masked;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_limit_q <= ccfr_pkg::BLK_LIMIT_RST;
			room_q      <= ccfr_pkg::ROOM_RST;
		end else if (cfg_valid) begin
			if (cfg_index == ccfr_pkg::REG_BLK_LIMIT) begin
				blk_limit_q <= cfg_data;
			end
			if (cfg_index == ccfr_pkg::REG_RESPONSE_ROOM) begin
				room_q <= cfg_data;
			end
		end
	end

	// card memory: one write port, one registered read port
	assign rd_addr = ctl.rd_blk0 ? '0 : blk_q;

	always_ff @(posedge clk) begin
		if (ctl.mem_we && ({1'b0, load_index} < 6'(ccfr_pkg::MAX_BLOCKS))) begin
			mem[load_index] <= payload;
		end
		if (ctl.rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// hold the request frame
	always_ff @(posedge clk) begin
		if (ctl.req_we) begin
			op_q  <= opcode;
			len_q <= frame_length;
			pay_q <= payload;
		end
	end

	// decode flags over the held frame and block 0
	assign rot_serial = {rdata_q[2:0], rdata_q[ccfr_pkg::PAYLOAD_W-1:3]};
	assign limit      = (blk_limit_q < 6'(ccfr_pkg::MAX_BLOCKS)) ? blk_limit_q
	                                                             : 6'(ccfr_pkg::MAX_BLOCKS);
	assign rd_end     = {1'b0, pay_q[7:0]} + ((op_q == ccfr_pkg::OP_READ_FOUR) ? 9'd4 : 9'd1);

	always_comb begin
		stat.len_zero  = (len_q == '0);
		stat.is_act    = (op_q == ccfr_pkg::OP_ACTIVATE) && (len_q == ccfr_pkg::LEN_SHORT);
		stat.is_ident  = (op_q == ccfr_pkg::OP_IDENTIFY) && (len_q == ccfr_pkg::LEN_SHORT);
		stat.is_sel    = (op_q == ccfr_pkg::OP_SELECT) && (len_q == ccfr_pkg::LEN_SELECT);
		stat.is_halt   = (op_q == ccfr_pkg::OP_HALT) && (len_q == ccfr_pkg::LEN_SHORT);
		stat.is_read   = ((op_q == ccfr_pkg::OP_READ_ONE) || (op_q == ccfr_pkg::OP_READ_FOUR))
		                 && (len_q == ccfr_pkg::LEN_READ);
		stat.rd_four   = (op_q == ccfr_pkg::OP_READ_FOUR);
		stat.match_rot = (pay_q == rot_serial);
		stat.match_raw = (pay_q == rdata_q);
		stat.crc_ok    = (ccfr_pkg::crc_byte(ccfr_pkg::CRC_INIT, pay_q[7:0]) == pay_q[23:8]);
		stat.range_ok  = (rd_end <= {3'b000, limit});
		stat.fit_word  = (room_q >= ccfr_pkg::RSP_LEN_WORD);
		stat.fit_read  = stat.rd_four ? (room_q >= ccfr_pkg::RSP_LEN_FOUR) : stat.fit_word;
	end

	// block address for reads
	assign blk_masked = (blk_q == ccfr_pkg::MASK_BLK_A) || (blk_q == ccfr_pkg::MASK_BLK_B);

	always_ff @(posedge clk) begin
		if (ctl.blk_init) begin
			blk_q <= pay_q[ccfr_pkg::IDX_W-1:0];
		end else if (ctl.blk_adv) begin
			blk_q <= blk_q + 1'b1;
		end
	end

	// response word: load, then shift one byte per data beat
	always_ff @(posedge clk) begin
		if (ctl.word_we) begin
			unique case (ctl.word_src)
				ccfr_pkg::WSRC_ROT: word_q <= rot_serial;
				ccfr_pkg::WSRC_RAW: word_q <= rdata_q;
				ccfr_pkg::WSRC_BLK: word_q <= blk_masked ? '1 : rdata_q;
				default:            word_q <= rdata_q;
			endcase
		end else if (ctl.out_we && (ctl.out_sel == ccfr_pkg::OSEL_DATA)) begin
			word_q <= word_q >> 8;
		end
	end

	// CRC over the data bytes as they go out
	always_ff @(posedge clk) begin
		if (ctl.crc_init) begin
			crc_q <= ccfr_pkg::CRC_INIT;
		end else if (ctl.out_we && (ctl.out_sel == ccfr_pkg::OSEL_DATA)) begin
			crc_q <= ccfr_pkg::crc_byte(crc_q, word_q[7:0]);
		end
	end

	// response output register
	always_ff @(posedge clk) begin
		if (ctl.out_we) begin
			unique case (ctl.out_sel)
				ccfr_pkg::OSEL_SINGLE: begin
					status    <= ctl.out_status;
					data_byte <= 8'h00;
					last      <= 1'b1;
				end
				ccfr_pkg::OSEL_DATA: begin
					status    <= ccfr_pkg::ST_BYTE;
					data_byte <= word_q[7:0];
					last      <= 1'b0;
				end
				ccfr_pkg::OSEL_CRC_LO: begin
					status    <= ccfr_pkg::ST_BYTE;
					data_byte <= crc_q[7:0];
					last      <= 1'b0;
				end
				ccfr_pkg::OSEL_CRC_HI: begin
					status    <= ccfr_pkg::ST_BYTE;
					data_byte <= crc_q[15:8];
					last      <= 1'b1;
				end
			endcase
		end
	end

endmodule

>>> rtl/ccfr_ctrl.sv
// ----------------------------------------------------------------------------
// ccfr_ctrl: controller of the card frame responder
// Session mode, request sequencing, block fetch and byte streaming; drives
// the datapath by command struct and owns the response valid flag.
// ----------------------------------------------------------------------------
module ccfr_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  logic                  req_cmd,
	input  logic                  rsp_ready,
	output logic                  rsp_valid,
	input  ccfr_pkg::ccfr_stat_t  stat,
	output ccfr_pkg::ccfr_ctl_t   ctl
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_FETCH  = 3'd1;
	localparam logic [2:0] S_EVAL   = 3'd2;
	localparam logic [2:0] S_RDREQ  = 3'd3;
	localparam logic [2:0] S_RDLOAD = 3'd4;
	localparam logic [2:0] S_EMIT   = 3'd5;
	localparam logic [2:0] S_CRCLO  = 3'd6;
	localparam logic [2:0] S_CRCHI  = 3'd7;

	localparam logic [1:0] MODE_IDLE     = 2'd0;
	localparam logic [1:0] MODE_ACTIVE   = 2'd1;
	localparam logic [1:0] MODE_SELECTED = 2'd2;
	localparam logic [1:0] MODE_HALTED   = 2'd3;

	logic [2:0] state_q, state_d;
	logic [1:0] mode_q, mode_d;
	logic [2:0] byte_cnt_q, byte_cnt_d;
	logic [1:0] blk_left_q, blk_left_d;
	logic       valid_q;
	logic       out_free;
	logic       accept;
	logic       mode_live;
	logic       sel_match;
	logic       do_single;
	logic       do_word;
	logic [ccfr_pkg::STATUS_W-1:0] single_status;

	assign accept    = req_valid && req_ready;
	assign out_free  = !valid_q || rsp_ready;
	assign mode_live = (mode_q == MODE_ACTIVE) || (mode_q == MODE_SELECTED);
	assign sel_match = mode_live ? stat.match_rot : stat.match_raw;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = valid_q;

	// decide the request outcome and sequence the response
	always_comb begin
		state_d       = state_q;
		mode_d        = mode_q;
		byte_cnt_d    = byte_cnt_q;
		blk_left_d    = blk_left_q;
		do_single     = 1'b0;
		do_word       = 1'b0;
		single_status = ccfr_pkg::ST_IGNORE;
		ctl           = '0;
		ctl.word_src  = ccfr_pkg::WSRC_RAW;
		ctl.out_sel   = ccfr_pkg::OSEL_SINGLE;

		unique case (state_q)
			S_IDLE: begin
				ctl.mem_we = accept && req_cmd;
				ctl.req_we = accept && !req_cmd;
				if (accept && !req_cmd) begin
					state_d = S_FETCH;
				end
			end
			S_FETCH: begin
				ctl.rd_en   = 1'b1;
				ctl.rd_blk0 = 1'b1;
				state_d     = S_EVAL;
			end
			S_EVAL: begin
				if (out_free) begin
					priority if (stat.len_zero) begin
						do_single     = 1'b1;
						single_status = ccfr_pkg::ST_ERROR;
					end else if (stat.is_act) begin
						mode_d        = MODE_ACTIVE;
						do_single     = 1'b1;
						single_status = ccfr_pkg::ST_SOF;
					end else if (stat.is_ident) begin
						if (!mode_live) begin
							do_single     = 1'b1;
							single_status = ccfr_pkg::ST_REJECT;
						end else if (!stat.fit_word) begin
							do_single     = 1'b1;
							single_status = ccfr_pkg::ST_ERROR;
						end else begin
							do_word      = 1'b1;
							ctl.word_src = ccfr_pkg::WSRC_ROT;
						end
					end else if (stat.is_sel) begin
						if (!sel_match) begin
							mode_d        = MODE_IDLE;
							do_single     = 1'b1;
							single_status = ccfr_pkg::ST_REJECT;
						end else begin
							mode_d = MODE_SELECTED;
							if (!stat.fit_word) begin
								do_single     = 1'b1;
								single_status = ccfr_pkg::ST_ERROR;
							end else begin
								do_word      = 1'b1;
								ctl.word_src = ccfr_pkg::WSRC_RAW;
							end
						end
					end else if (stat.is_halt) begin
						do_single = 1'b1;
						if (mode_q != MODE_SELECTED) begin
							single_status = ccfr_pkg::ST_REJECT;
						end else begin
							mode_d        = MODE_HALTED;
							single_status = ccfr_pkg::ST_SOF;
						end
					end else if (stat.is_read) begin
						if (mode_q != MODE_SELECTED) begin
							do_single     = 1'b1;
							single_status = ccfr_pkg::ST_REJECT;
						end else if (!stat.crc_ok) begin
							do_single     = 1'b1;
							single_status = ccfr_pkg::ST_IGNORE;
						end else if (!stat.range_ok) begin
							do_single     = 1'b1;
							single_status = ccfr_pkg::ST_REJECT;
						end else if (!stat.fit_read) begin
							do_single     = 1'b1;
							single_status = ccfr_pkg::ST_ERROR;
						end else begin
							ctl.blk_init = 1'b1;
							ctl.crc_init = 1'b1;
							blk_left_d   = stat.rd_four ? 2'd3 : 2'd0;
							state_d      = S_RDREQ;
						end
					end else begin
						do_single     = 1'b1;
						single_status = ccfr_pkg::ST_IGNORE;
					end
				end
				if (do_single) begin
					ctl.out_we     = 1'b1;
					ctl.out_sel    = ccfr_pkg::OSEL_SINGLE;
					ctl.out_status = single_status;
					state_d        = S_IDLE;
				end
				if (do_word) begin
					ctl.word_we = 1'b1;
					ctl.crc_init = 1'b1;
					byte_cnt_d  = '0;
					blk_left_d  = '0;
					state_d     = S_EMIT;
				end
			end
			S_RDREQ: begin
				ctl.rd_en = 1'b1;
				state_d   = S_RDLOAD;
			end
			S_RDLOAD: begin
				ctl.word_we  = 1'b1;
				ctl.word_src = ccfr_pkg::WSRC_BLK;
				byte_cnt_d   = '0;
				state_d      = S_EMIT;
			end
			S_EMIT: begin
				if (out_free) begin
					ctl.out_we  = 1'b1;
					ctl.out_sel = ccfr_pkg::OSEL_DATA;
					byte_cnt_d  = byte_cnt_q + 1'b1;
					if (byte_cnt_q == 3'd7) begin
						if (blk_left_q != '0) begin
							blk_left_d  = blk_left_q - 1'b1;
							ctl.blk_adv = 1'b1;
							state_d     = S_RDREQ;
						end else begin
							state_d = S_CRCLO;
						end
					end
				end
			end
			S_CRCLO: begin
				if (out_free) begin
					ctl.out_we  = 1'b1;
					ctl.out_sel = ccfr_pkg::OSEL_CRC_LO;
					state_d     = S_CRCHI;
				end
			end
			S_CRCHI: begin
				if (out_free) begin
					ctl.out_we  = 1'b1;
					ctl.out_sel = ccfr_pkg::OSEL_CRC_HI;
					state_d     = S_IDLE;
				end
			end
		endcase
	end

	// advance state, mode and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			mode_q     <= MODE_IDLE;
			byte_cnt_q <= '0;
			blk_left_q <= '0;
		end else begin
			state_q    <= state_d;
			mode_q     <= mode_d;
			byte_cnt_q <= byte_cnt_d;
			blk_left_q <= blk_left_d;
		end
	end

	// hold the response beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.out_we) begin
			valid_q <= 1'b1;
		end else if (rsp_ready) begin
			valid_q <= 1'b0;
		end
	end

	a_out_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_we |-> out_free)
		else $error("response beat loaded over an untaken beat");

	a_eval_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EVAL) && out_free |=> (state_q != S_EVAL))
		else $error("request evaluated twice");

	a_mode_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_EVAL) |=> $stable(mode_q))
		else $error("session mode changed outside evaluation");

	a_crc_after_data: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CRCLO) |-> (byte_cnt_q == '0) && (blk_left_q == '0))
		else $error("CRC sent before all data bytes");

endmodule

>>> rtl/contactless_card_frame_responder.sv
// ----------------------------------------------------------------------------
// contactless_card_frame_responder: card side of a contactless exchange
// Answers activate, identify, select, halt and block read frames from a
// 32-block card memory; load items fill the memory.
// ----------------------------------------------------------------------------
// Sequencing: a load item is written as it is accepted; a frame is held,
//   block 0 fetched and the frame decided (S_FETCH, S_EVAL); a block read
//   fetches each block from memory (S_RDREQ, S_RDLOAD), sends its bytes
//   (S_EMIT), then the CRC; no new request before the last beat is loaded.
// Reset: session mode idle, block limit 32, response room 34; card memory is
//   not cleared and needs loading before use.
module contactless_card_frame_responder (
	input logic     clk,
	input logic     arst_n,
	ccfr_req_if.sink   req,
	ccfr_rsp_if.source rsp,
	ccfr_cfg_if.sink   cfg
);

	ccfr_pkg::ccfr_ctl_t  ctl;
	ccfr_pkg::ccfr_stat_t stat;

	// configuration writes are always taken
	assign cfg.ready = 1'b1;

	ccfr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.req_cmd   (req.cmd),
		.rsp_ready (rsp.ready),
		.rsp_valid (rsp.valid),
		.stat      (stat),
		.ctl       (ctl)
	);

	ccfr_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.stat         (stat),
		.opcode       (req.opcode),
		.frame_length (req.frame_length),
		.payload      (req.payload),
		.load_index   (req.load_index),
		.cfg_valid    (cfg.valid),
		.cfg_index    (cfg.index),
		.cfg_data     (cfg.data),
		.status       (rsp.status),
		.data_byte    (rsp.data_byte),
		.last         (rsp.last)
	);

endmodule

>>> dv/card_answer_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// card_answer_checker: response predictor and comparator for the card responder
// Watches the request, response and configuration channels, keeps its own
// session mode, card memory and registers, and compares every response beat
// with the oldest predicted beat, field by field.
// ----------------------------------------------------------------------------
module card_answer_checker (
	input  logic        clk,
	input  logic        arst_n,
	ccfr_req_if         req,
	ccfr_rsp_if         rsp,
	ccfr_cfg_if         cfg,
	output int unsigned fail_count,
	output int unsigned answers_pending,
	output int unsigned frames_seen,
	output int unsigned loads_seen,
	output int unsigned beats_checked
);

	typedef enum logic [1:0] {
		SESS_IDLE,
		SESS_ACTIVE,
		SESS_SELECTED,
		SESS_HALTED
	} sess_t;

	typedef struct packed {
		logic [ccfr_pkg::STATUS_W-1:0] status;
		logic [7:0]                    data_byte;
		logic                          last;
	} beat_t;

	sess_t                           sess;
	logic [ccfr_pkg::PAYLOAD_W-1:0]  card_mem [ccfr_pkg::MAX_BLOCKS];
	logic [ccfr_pkg::CFG_DATA_W-1:0] blk_limit_q;
	logic [ccfr_pkg::CFG_DATA_W-1:0] room_q;
	beat_t                           answer_beats [$];

	// bit-serial reflected CRC-16, data bits fed LSB first
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] r;
		logic        fb;
		r = crc;
		for (int k = 0; k < 8; k++) begin
			fb = r[0] ^ b[k];
			r  = {1'b0, r[15:1]};
			if (fb) r = r ^ ccfr_pkg::CRC_POLY;
		end
		return r;
	endfunction

	function automatic void push_single(input logic [ccfr_pkg::STATUS_W-1:0] st);
		beat_t bt;
		bt.status    = st;
		bt.data_byte = '0;
		bt.last      = 1'b1;
		answer_beats.push_back(bt);
	endfunction

	// queue n data bytes plus CRC, or one error beat when they do not fit
	function automatic void push_data(input logic [7:0] msg [32], input int n);
		beat_t       bt;
		logic [15:0] crc;
		int          total;
		total = n + 2;
		if (total > int'(room_q)) begin
			push_single(ccfr_pkg::ST_ERROR);
			return;
		end
		crc = ccfr_pkg::CRC_INIT;
		for (int i = 0; i < n; i++) crc = crc_feed(crc, msg[i]);
		for (int i = 0; i < total; i++) begin
			bt.status = ccfr_pkg::ST_BYTE;
			if (i < n) bt.data_byte = msg[i];
			else if (i == n) bt.data_byte = crc[7:0];
			else bt.data_byte = crc[15:8];
			bt.last = (i == total - 1);
			answer_beats.push_back(bt);
		end
	endfunction

	function automatic void push_word(input logic [63:0] w);
		logic [7:0] msg [32];
		for (int i = 0; i < 32; i++) msg[i] = (i < 8) ? w[8*i +: 8] : 8'h00;
		push_data(msg, 8);
	endfunction

	// decode one request frame, update the session and queue its answer
	function automatic void answer_frame(input logic [ccfr_pkg::OPCODE_W-1:0] op,
		input logic [ccfr_pkg::LEN_W-1:0] len, input logic [ccfr_pkg::PAYLOAD_W-1:0] pay);
		logic [63:0] serial;
		logic [63:0] rot;
		logic [63:0] want;
		logic [7:0]  msg [32];
		logic [7:0]  first;
		logic [15:0] got;
		int          count;
		int          limit;
		int          blk;
		serial = card_mem[0];
		rot    = {serial[2:0], serial[63:3]};
		first  = pay[7:0];
		got    = pay[23:8];
		count  = (op == ccfr_pkg::OP_READ_FOUR) ? 4 : 1;
		limit  = (int'(blk_limit_q) < int'(ccfr_pkg::MAX_BLOCKS)) ? int'(blk_limit_q)
			: int'(ccfr_pkg::MAX_BLOCKS);
		for (int i = 0; i < 32; i++) msg[i] = 8'h00;
		if (len == '0) begin
			push_single(ccfr_pkg::ST_ERROR);
		end else if (op == ccfr_pkg::OP_ACTIVATE && len == ccfr_pkg::LEN_SHORT) begin
			sess = SESS_ACTIVE;
			push_single(ccfr_pkg::ST_SOF);
		end else if (op == ccfr_pkg::OP_IDENTIFY && len == ccfr_pkg::LEN_SHORT) begin
			if (sess == SESS_ACTIVE || sess == SESS_SELECTED) push_word(rot);
			else push_single(ccfr_pkg::ST_REJECT);
		end else if (op == ccfr_pkg::OP_SELECT && len == ccfr_pkg::LEN_SELECT) begin
			// rotated serial while active or selected, raw serial otherwise
			want = (sess == SESS_ACTIVE || sess == SESS_SELECTED) ? rot : serial;
			if (pay != want) begin
				sess = SESS_IDLE;
				push_single(ccfr_pkg::ST_REJECT);
			end else begin
				sess = SESS_SELECTED;
				push_word(serial);
			end
		end else if (op == ccfr_pkg::OP_HALT && len == ccfr_pkg::LEN_SHORT) begin
			if (sess != SESS_SELECTED) begin
				push_single(ccfr_pkg::ST_REJECT);
			end else begin
				sess = SESS_HALTED;
				push_single(ccfr_pkg::ST_SOF);
			end
		end else if ((op == ccfr_pkg::OP_READ_ONE || op == ccfr_pkg::OP_READ_FOUR)
			&& len == ccfr_pkg::LEN_READ) begin
			if (sess != SESS_SELECTED) begin
				push_single(ccfr_pkg::ST_REJECT);
			end else if (crc_feed(ccfr_pkg::CRC_INIT, first) != got) begin
				push_single(ccfr_pkg::ST_IGNORE);
			end else if (int'(first) >= limit || count > limit - int'(first)) begin
				push_single(ccfr_pkg::ST_REJECT);
			end else begin
				// gather blocks, masked blocks read as all ones
				for (int k = 0; k < count; k++) begin
					blk = int'(first) + k;
					for (int i = 0; i < 8; i++) begin
						msg[k*8 + i] = (blk == int'(ccfr_pkg::MASK_BLK_A) ||
							blk == int'(ccfr_pkg::MASK_BLK_B)) ?
							8'hFF : card_mem[blk][8*i +: 8];
					end
				end
				push_data(msg, count * 8);
			end
		end else begin
			push_single(ccfr_pkg::ST_IGNORE);
		end
	endfunction

	// monitor all three channels at each edge
	always @(posedge clk or negedge arst_n) begin : monitor
		beat_t exp_b;
		if (!arst_n) begin
			sess            = SESS_IDLE;
			blk_limit_q     = ccfr_pkg::BLK_LIMIT_RST;
			room_q          = ccfr_pkg::ROOM_RST;
			fail_count      = 0;
			frames_seen     = 0;
			loads_seen      = 0;
			beats_checked   = 0;
			answer_beats.delete();
			answers_pending = 0;
		end else begin
			// compare a response beat with the oldest prediction
			if (rsp.valid && rsp.ready) begin
				if (answer_beats.size() == 0) begin
					$error("unexpected response beat: status %0d data_byte %02h last %0b",
						rsp.status, rsp.data_byte, rsp.last);
					fail_count++;
				end else begin
					exp_b = answer_beats.pop_front();
					beats_checked++;
					if (rsp.status !== exp_b.status) begin
						$error("status: expected %0d, actual %0d", exp_b.status, rsp.status);
						fail_count++;
					end
					if (rsp.data_byte !== exp_b.data_byte) begin
						$error("data_byte: expected %02h, actual %02h",
							exp_b.data_byte, rsp.data_byte);
						fail_count++;
					end
					if (rsp.last !== exp_b.last) begin
						$error("last: expected %0b, actual %0b", exp_b.last, rsp.last);
						fail_count++;
					end
				end
			end
			// track register writes
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == ccfr_pkg::REG_BLK_LIMIT) blk_limit_q = cfg.data;
				else if (cfg.index == ccfr_pkg::REG_RESPONSE_ROOM) room_q = cfg.data;
			end
			// predict from each accepted request beat
			if (req.valid && req.ready) begin
				if (req.cmd) begin
					card_mem[req.load_index] = req.payload;
					loads_seen++;
				end else begin
					answer_frame(req.opcode, req.frame_length, req.payload);
					frames_seen++;
				end
			end
			answers_pending = answer_beats.size();
		end
	end

endmodule

>>> dv/tb_contactless_card_frame_responder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_contactless_card_frame_responder: top of the card responder testbench
// Fills the card memory, runs a directed set of frames, then random sessions
// and noise under several register settings with bursty requests and a
// stalling response side; the checker predicts and compares every beat.
// ----------------------------------------------------------------------------
module tb_contactless_card_frame_responder;

	localparam int unsigned PHASES       = 6;
	localparam int unsigned PHASE_ITEMS  = 22;
	localparam logic [ccfr_pkg::OPCODE_W-1:0] OP_UNUSED    = 8'hFF;
	localparam logic [ccfr_pkg::LEN_W-1:0]    LEN_EMPTY    = 4'd0;
	localparam logic [ccfr_pkg::LEN_W-1:0]    LEN_OVERSIZE = 4'hF;

	// register settings per random phase, extremes included
	localparam logic [ccfr_pkg::CFG_DATA_W-1:0] PH_LIMIT [PHASES] =
		'{6'd32, 6'd6, 6'd32, 6'd13, 6'd6, 6'd25};
	localparam logic [ccfr_pkg::CFG_DATA_W-1:0] PH_ROOM  [PHASES] =
		'{6'd34, 6'd34, 6'd10, 6'd33, 6'd9, 6'd0};

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	ccfr_req_if req_ch ();
	ccfr_rsp_if rsp_ch ();
	ccfr_cfg_if cfg_ch ();

	int unsigned fail_count;
	int unsigned answers_pending;
	int unsigned frames_seen;
	int unsigned loads_seen;
	int unsigned beats_checked;

	logic [63:0]                     serial_sh;
	logic [ccfr_pkg::CFG_DATA_W-1:0] cur_limit;
	int unsigned                     items_sent;
	int unsigned                     burst_left;
	bit                              rsp_stalled;
	int unsigned                     stall_left;

	contactless_card_frame_responder u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	card_answer_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.req             (req_ch),
		.rsp             (rsp_ch),
		.cfg             (cfg_ch),
		.fail_count      (fail_count),
		.answers_pending (answers_pending),
		.frames_seen     (frames_seen),
		.loads_seen      (loads_seen),
		.beats_checked   (beats_checked)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// stall the response side: long ready stretches broken by stalls
	assign rsp_ch.ready = ~rsp_stalled;

	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 2) != 0) begin
			rsp_stalled <= 1'b0;
			stall_left  <= $urandom_range(1, 60);
		end else begin
			rsp_stalled <= 1'b1;
			stall_left  <= $urandom_range(1, 20);
		end
	end

	// drive one request beat, opening a new burst after a random gap
	task automatic send_item(input logic c, input logic [ccfr_pkg::OPCODE_W-1:0] op,
		input logic [ccfr_pkg::LEN_W-1:0] len, input logic [ccfr_pkg::PAYLOAD_W-1:0] pay,
		input logic [ccfr_pkg::IDX_W-1:0] idx);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 45);
			if (gap != 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 10);
		end
		req_ch.valid        <= 1'b1;
		req_ch.cmd          <= c;
		req_ch.opcode       <= op;
		req_ch.frame_length <= len;
		req_ch.payload      <= pay;
		req_ch.load_index   <= idx;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		burst_left--;
		items_sent++;
		if (c && idx == '0) serial_sh = pay;
	endtask

	task automatic send_frame(input logic [ccfr_pkg::OPCODE_W-1:0] op,
		input logic [ccfr_pkg::LEN_W-1:0] len, input logic [ccfr_pkg::PAYLOAD_W-1:0] pay);
		send_item(1'b0, op, len, pay, ccfr_pkg::IDX_W'($urandom));
	endtask

	task automatic send_load(input logic [ccfr_pkg::IDX_W-1:0] idx,
		input logic [ccfr_pkg::PAYLOAD_W-1:0] data);
		send_item(1'b1, ccfr_pkg::OPCODE_W'($urandom), ccfr_pkg::LEN_W'($urandom), data, idx);
	endtask

	// read request with a good or a corrupted CRC over the first block byte
	task automatic send_read(input logic [ccfr_pkg::OPCODE_W-1:0] op, input logic [7:0] first,
		input bit good);
		logic [15:0] crc;
		crc = ccfr_pkg::crc_byte(ccfr_pkg::CRC_INIT, first);
		if (!good) crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
		send_frame(op, ccfr_pkg::LEN_READ, {$urandom, 8'($urandom), crc, first});
	endtask

	// first block mostly in range, sometimes at the edge or far out
	function automatic logic [7:0] pick_first();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 7) return 8'($urandom_range(0, int'(cur_limit) - 1));
		else if (r < 9) return 8'($urandom_range(int'(cur_limit) - 4, int'(cur_limit) + 1));
		return 8'($urandom);
	endfunction

	task automatic send_reads(input int unsigned n);
		repeat (n) begin
			send_read($urandom_range(0, 1) ? ccfr_pkg::OP_READ_FOUR : ccfr_pkg::OP_READ_ONE,
				pick_first(), $urandom_range(0, 9) != 0);
		end
	endtask

	// mostly well-formed session: activate, select, reads, halt and reselect
	task automatic run_session();
		logic [63:0] sel_pay;
		bit          selected;
		send_frame(ccfr_pkg::OP_ACTIVATE, ccfr_pkg::LEN_SHORT, {$urandom, $urandom});
		if ($urandom_range(0, 1))
			send_frame(ccfr_pkg::OP_IDENTIFY, ccfr_pkg::LEN_SHORT, {$urandom, $urandom});
		sel_pay  = {serial_sh[2:0], serial_sh[63:3]};
		selected = 1'b1;
		if ($urandom_range(0, 9) == 0) begin
			sel_pay  = sel_pay ^ (64'd1 << $urandom_range(0, 63));
			selected = 1'b0;
		end
		send_frame(ccfr_pkg::OP_SELECT, ccfr_pkg::LEN_SELECT, sel_pay);
		if (selected) begin
			send_reads($urandom_range(1, 4));
			if ($urandom_range(0, 4) == 0)
				send_frame(ccfr_pkg::OP_IDENTIFY, ccfr_pkg::LEN_SHORT, {$urandom, $urandom});
			if ($urandom_range(0, 4) < 3) begin
				send_frame(ccfr_pkg::OP_HALT, ccfr_pkg::LEN_SHORT, {$urandom, $urandom});
				if ($urandom_range(0, 4) < 2) begin
					send_frame(ccfr_pkg::OP_SELECT, ccfr_pkg::LEN_SELECT, serial_sh);
					send_reads(1);
				end
			end
		end
	endtask

	// stray load or frame with random opcode, length and payload
	task automatic send_noise();
		logic [ccfr_pkg::OPCODE_W-1:0] op;
		logic [ccfr_pkg::LEN_W-1:0]    len;
		if ($urandom_range(0, 9) < 3) begin
			send_load(ccfr_pkg::IDX_W'($urandom), {$urandom, $urandom});
		end else begin
			case ($urandom_range(0, 6))
				0: op = ccfr_pkg::OP_ACTIVATE;
				1: op = ccfr_pkg::OP_IDENTIFY;
				2: op = ccfr_pkg::OP_SELECT;
				3: op = ccfr_pkg::OP_HALT;
				4: op = ccfr_pkg::OP_READ_FOUR;
				default: op = ccfr_pkg::OPCODE_W'($urandom);
			endcase
			len = ($urandom_range(0, 2) == 0) ? ccfr_pkg::LEN_SHORT : ccfr_pkg::LEN_W'($urandom);
			send_frame(op, len, {$urandom, $urandom});
		end
	endtask

	task automatic write_reg(input logic [ccfr_pkg::CFG_IDX_W-1:0] idx,
		input logic [ccfr_pkg::CFG_DATA_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
		if (idx == ccfr_pkg::REG_BLK_LIMIT) cur_limit = val;
	endtask

	// drop valid, wait for every predicted beat, then let a load finish
	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (answers_pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin : stimulus
		int unsigned goal;
		req_ch.valid        <= 1'b0;
		req_ch.cmd          <= 1'b0;
		req_ch.opcode       <= '0;
		req_ch.frame_length <= '0;
		req_ch.payload      <= '0;
		req_ch.load_index   <= '0;
		cfg_ch.valid        <= 1'b0;
		cfg_ch.index        <= '0;
		cfg_ch.data         <= '0;
		burst_left = 0;
		items_sent = 0;
		cur_limit  = ccfr_pkg::BLK_LIMIT_RST;
		serial_sh  = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// fill every card block; one all zeros, one all ones
		for (int b = 0; b < int'(ccfr_pkg::MAX_BLOCKS); b++) begin
			if (b == 5) send_load(ccfr_pkg::IDX_W'(b), 64'h0);
			else if (b == 6) send_load(ccfr_pkg::IDX_W'(b), '1);
			else send_load(ccfr_pkg::IDX_W'(b), {$urandom, $urandom});
		end

		// directed frames under reset register values
		send_frame(ccfr_pkg::OP_ACTIVATE, LEN_EMPTY, {$urandom, $urandom});
		send_frame(ccfr_pkg::OP_IDENTIFY, ccfr_pkg::LEN_SHORT, {$urandom, $urandom});
		send_frame(ccfr_pkg::OP_HALT, ccfr_pkg::LEN_SHORT, {$urandom, $urandom});
		send_read(ccfr_pkg::OP_READ_ONE, 8'd0, 1'b1);
		send_frame(ccfr_pkg::OP_SELECT, ccfr_pkg::LEN_SELECT, serial_sh);
		send_read(ccfr_pkg::OP_READ_ONE, 8'd0, 1'b1);
		send_frame(ccfr_pkg::OP_ACTIVATE, ccfr_pkg::LEN_SHORT, {$urandom, $urandom});
		send_frame(ccfr_pkg::OP_IDENTIFY, ccfr_pkg::LEN_SHORT, {$urandom, $urandom});
		send_frame(ccfr_pkg::OP_SELECT, ccfr_pkg::LEN_SELECT, serial_sh);
		send_frame(ccfr_pkg::OP_ACTIVATE, ccfr_pkg::LEN_SHORT, {$urandom, $urandom});
		send_frame(ccfr_pkg::OP_SELECT, ccfr_pkg::LEN_SELECT,
			{serial_sh[2:0], serial_sh[63:3]});
		send_read(ccfr_pkg::OP_READ_FOUR, 8'd2, 1'b1);
		send_read(ccfr_pkg::OP_READ_ONE, 8'd31, 1'b1);
		send_read(ccfr_pkg::OP_READ_FOUR, 8'd29, 1'b1);
		send_read(ccfr_pkg::OP_READ_ONE, 8'd32, 1'b1);
		send_read(ccfr_pkg::OP_READ_ONE, 8'd5, 1'b0);
		send_read(ccfr_pkg::OP_READ_FOUR, 8'd255, 1'b1);
		send_frame(ccfr_pkg::OP_IDENTIFY, ccfr_pkg::LEN_SHORT, {$urandom, $urandom});
		send_frame(OP_UNUSED, ccfr_pkg::LEN_SHORT, {$urandom, $urandom});
		send_frame(ccfr_pkg::OP_ACTIVATE, LEN_OVERSIZE, {$urandom, $urandom});
		send_frame(ccfr_pkg::OP_HALT, ccfr_pkg::LEN_SHORT, {$urandom, $urandom});
		send_frame(ccfr_pkg::OP_HALT, ccfr_pkg::LEN_SHORT, {$urandom, $urandom});
		send_frame(ccfr_pkg::OP_SELECT, ccfr_pkg::LEN_SELECT, serial_sh);
		send_read(ccfr_pkg::OP_READ_FOUR, 8'd28, 1'b1);
		send_read(ccfr_pkg::OP_READ_ONE, 8'd6, 1'b1);
		drain();

		// random phases, registers rewritten while idle
		for (int ph = 0; ph < int'(PHASES); ph++) begin
			write_reg(ccfr_pkg::REG_BLK_LIMIT, PH_LIMIT[ph]);
			write_reg(ccfr_pkg::REG_RESPONSE_ROOM, PH_ROOM[ph]);
			goal = items_sent + PHASE_ITEMS;
			while (items_sent < goal) begin
				if ($urandom_range(0, 9) < 7) run_session();
				else send_noise();
			end
			drain();
		end
		repeat (20) @(posedge clk);

		$display("Run covered %0d request frames and %0d block loads, %s %0d settings",
			frames_seen, loads_seen, "reset values plus", PHASES);
		$display("%0d response beats compared in order against the prediction", beats_checked);
		if (fail_count == 0 && answers_pending == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// end a hung run
	initial begin : watchdog
		#4_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
